// File: rtl/mmbb_pkg.sv
// Shared types and constants of the multi-mode block byte buffer.
// No dependencies; imported by the controller, the datapath and the top level.
package mmbb_pkg;

    // field widths
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;

    // input selector values
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // buffer modes (mode 3 behaves as circular)
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_DOUBLE = 2'd1;
    localparam logic [1:0] MODE_CIRC   = 2'd2;

    // register indexes
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_item;        // latch the accepted input beat
        logic exec_write;       // apply one write byte
        logic rd_start;         // set up a block read
        logic rd_issue;         // issue one store read
        logic out_load_status;  // put a status result in the output register
        logic out_load_data;    // move the read stage into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;     // held item is a read
        logic rd_fail;     // held read is refused
        logic wr_emits;    // held write byte gives a status result
        logic issue_last;  // current read index is the last of the block
        logic out_valid;   // output register is full
    } t_stat;

endpackage

// File: rtl/mmbb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mmbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/mmbb_ctrl.sv
// Controller state machine of the block byte buffer: sequences writes, reads and results.
// Depends on mmbb_pkg (command and status structs).
module mmbb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_m_tready,
    input  mmbb_pkg::t_stat i_stat,
    output mmbb_pkg::t_cmd  o_cmd
);
    import mmbb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_issuing, n_issuing;
    logic       r_pipe_v, n_pipe_v;
    logic       out_free;
    logic       pipe_move;
    logic       issue;

    assign out_free  = !i_stat.out_valid || i_m_tready;
    assign pipe_move = (r_state == S_READ) && r_pipe_v && out_free;
    assign issue     = (r_state == S_READ) && r_issuing && (!r_pipe_v || out_free);

    assign o_s_tready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_issuing = r_issuing;
        n_pipe_v  = r_pipe_v;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_read) begin
                    if (i_stat.rd_fail) begin
                        if (out_free) begin
                            o_cmd.out_load_status = 1'b1;
                            n_state               = S_IDLE;
                        end
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_issuing      = 1'b1;
                        n_pipe_v       = 1'b0;
                        n_state        = S_READ;
                    end
                end else if (!i_stat.wr_emits || out_free) begin
                    o_cmd.exec_write      = 1'b1;
                    o_cmd.out_load_status = i_stat.wr_emits;
                    n_state               = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue      = issue;
                o_cmd.out_load_data = pipe_move;
                if (issue) begin
                    n_pipe_v = 1'b1;
                end else if (pipe_move) begin
                    n_pipe_v = 1'b0;
                end
                if (issue && i_stat.issue_last) begin
                    n_issuing = 1'b0;
                end
                if (!r_issuing && pipe_move) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_pipe_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_pipe_v  <= n_pipe_v;
        end
    end
endmodule

// File: rtl/mmbb_dp.sv
// Datapath of the block byte buffer: item register, pointers, bank lengths, byte store, output register.
// Depends on mmbb_pkg and mmbb_ram.
module mmbb_dp #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_func,
    input  logic [mmbb_pkg::LEN_W-1:0]   i_len,
    input  logic [mmbb_pkg::BYTE_W-1:0]  i_wbyte,
    input  logic                         i_first,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mmbb_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_m_tready,
    input  mmbb_pkg::t_cmd               i_cmd,
    output mmbb_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic                         o_out_kind,
    output logic [mmbb_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_out_ok,
    output logic                         o_out_last
);
    import mmbb_pkg::*;

    localparam int PW = $clog2(STORE_DEPTH);          // pointer / index bits
    localparam int SW = $clog2(STORE_DEPTH + 1);      // size and bank length bits
    localparam int CW = (SW > LEN_W) ? SW : LEN_W;    // compare width
    localparam int AW = PW + 1;                        // store address bits
    localparam int SIZE_RST = (STORE_DEPTH < 64) ? STORE_DEPTH : 64;

    // configuration
    logic [1:0]        r_mode;
    logic [SW-1:0]     r_size;
    logic [SW-1:0]     cfg_size;

    // held item
    logic              r_func;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_wbyte;
    logic              r_first;

    // buffer state
    logic [PW-1:0]     r_rp;
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_wpos;
    logic [SW-1:0]     r_blen0;
    logic [SW-1:0]     r_blen1;
    logic              r_ab;
    logic [LEN_W-1:0]  r_rem;
    logic              r_acc;

    // read sequencing
    logic [PW-1:0]     r_rd_idx;
    logic [PW-1:0]     r_rptr;
    logic              r_p_zero;
    logic              r_p_last;

    // output register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_ok;
    logic              r_out_last;

    logic              circ;
    logic [CW-1:0]     size_c;
    logic [CW-1:0]     len_c;
    logic [CW-1:0]     head_c;
    logic [CW-1:0]     tail_c;
    logic [CW-1:0]     stored;
    logic [CW-1:0]     free_sp;
    logic              len_bad;
    logic              rd_fail;
    logic              wr_bad;
    logic              wr_go;
    logic              wr_emits;
    logic [LEN_W-1:0]  rem_next;
    logic [PW-1:0]     wpos;
    logic [PW-1:0]     wpos_inc;
    logic              wbank;
    logic [SW-1:0]     blen_w;
    logic [PW-1:0]     widx;
    logic [SW-1:0]     blen_r;
    logic [CW:0]       rp_sum;
    logic [PW-1:0]     rp_end;
    logic [PW-1:0]     rptr_inc;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rdata;

    assign circ   = r_mode[1];
    assign size_c = CW'(r_size);
    assign len_c  = CW'(r_len);
    assign head_c = CW'(r_rp);
    assign tail_c = CW'(r_wp);

    // fifo fill and free space
    assign stored  = (tail_c >= head_c) ? (tail_c - head_c) : (size_c - head_c + tail_c);
    assign free_sp = (head_c > tail_c) ? (head_c - tail_c) : (size_c - tail_c + head_c);

    // refusal checks
    assign len_bad = (r_len == '0) || (len_c > size_c);
    assign rd_fail = len_bad || (circ && (len_c > stored));
    assign wr_bad  = len_bad || (circ && (free_sp <= len_c));

    // write step decisions
    assign wr_go    = r_first ? !wr_bad : r_acc;
    assign rem_next = (r_first ? r_len : r_rem) - LEN_W'(1);
    assign wr_emits = r_first ? (wr_bad || (r_len == LEN_W'(1)))
                              : (r_acc && (r_rem == LEN_W'(1)));

    // circular write slot
    assign wpos     = r_first ? r_wp : r_wpos;
    assign wpos_inc = ((CW'(wpos) + CW'(1)) == size_c) ? '0 : (wpos + PW'(1));

    // bank write slot
    assign wbank  = (r_first && (r_mode == MODE_DOUBLE)) ? !r_ab : r_ab;
    assign blen_w = wbank ? r_blen1 : r_blen0;
    assign widx   = r_first ? '0 : blen_w[PW-1:0];

    // read pointer after a block read
    assign rp_sum = (CW+1)'(r_rp) + (CW+1)'(r_len);
    assign rp_end = (rp_sum >= (CW+1)'(r_size)) ? PW'(rp_sum - (CW+1)'(r_size)) : PW'(rp_sum);
    assign rptr_inc = ((CW'(r_rptr) + CW'(1)) == size_c) ? '0 : (r_rptr + PW'(1));
    assign blen_r   = r_ab ? r_blen1 : r_blen0;

    // store ports
    assign we    = i_cmd.exec_write && wr_go;
    assign waddr = circ ? {1'b0, wpos} : {wbank, widx};
    assign raddr = circ ? {1'b0, r_rptr} : {r_ab, r_rd_idx};

    // effective buffer size from a config write
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = SW'(1);
        end else if (CW'(i_cfg_data) > CW'(STORE_DEPTH)) begin
            cfg_size = SW'(STORE_DEPTH);
        end else begin
            cfg_size = SW'(i_cfg_data);
        end
    end

    // held input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func  <= i_func;
            r_len   <= i_len;
            r_wbyte <= i_wbyte;
            r_first <= i_first;
        end
    end

    // configuration, pointers, bank lengths and open block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CIRC;
            r_size  <= SW'(SIZE_RST);
            r_rp    <= '0;
            r_wp    <= '0;
            r_wpos  <= '0;
            r_blen0 <= '0;
            r_blen1 <= '0;
            r_ab    <= 1'b0;
            r_rem   <= '0;
            r_acc   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else begin
                r_size <= cfg_size;
            end
            r_rp    <= '0;
            r_wp    <= '0;
            r_wpos  <= '0;
            r_blen0 <= '0;
            r_blen1 <= '0;
            r_ab    <= 1'b0;
            r_rem   <= '0;
            r_acc   <= 1'b0;
        end else begin
            if (i_cmd.exec_write) begin
                if (wr_go) begin
                    r_rem <= rem_next;
                    r_acc <= (rem_next != '0);
                    if (circ) begin
                        r_wpos <= wpos_inc;
                        if (rem_next == '0) begin
                            r_wp <= wpos_inc;
                        end
                    end else begin
                        r_ab <= wbank;
                        if (wbank) begin
                            r_blen1 <= SW'(widx) + SW'(1);
                        end else begin
                            r_blen0 <= SW'(widx) + SW'(1);
                        end
                    end
                end else if (r_first) begin
                    r_rem <= '0;
                    r_acc <= 1'b0;
                end
            end
            if (i_cmd.rd_start && circ) begin
                r_rp <= rp_end;
            end
        end
    end

    // read index, fifo read pointer and read stage tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
            r_rptr   <= r_rp;
        end else if (i_cmd.rd_issue) begin
            r_rd_idx <= r_rd_idx + PW'(1);
            r_rptr   <= rptr_inc;
            r_p_zero <= !circ && (SW'(r_rd_idx) >= blen_r);
            r_p_last <= o_stat.issue_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_status || i_cmd.out_load_data) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_status) begin
            r_out_kind <= KIND_STATUS;
            r_out_byte <= '0;
            r_out_ok   <= (r_func == FUNC_WRITE) && !(r_first && wr_bad);
            r_out_last <= 1'b1;
        end else if (i_cmd.out_load_data) begin
            r_out_kind <= KIND_DATA;
            r_out_byte <= r_p_zero ? '0 : rdata;
            r_out_ok   <= 1'b1;
            r_out_last <= r_p_last;
        end
    end

    // byte store, two banks
    mmbb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(r_wbyte),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // status towards the controller
    assign o_stat.is_read    = (r_func == FUNC_READ);
    assign o_stat.rd_fail    = rd_fail;
    assign o_stat.wr_emits   = wr_emits;
    assign o_stat.issue_last = (CW'(r_rd_idx) + CW'(1)) == len_c;
    assign o_stat.out_valid  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_ok    = r_out_ok;
    assign o_out_last  = r_out_last;
endmodule

// File: rtl/multi_mode_block_byte_buffer_core.sv
// Write beat: the execute state applies the byte and loads any status into the output register.
// Read beat: first byte through the execute state, store read port and output register, then one
// byte per cycle unless the output stalls; the next beat is taken after the last byte leaves the read stage.
// A refused read gives its status from the execute state. Results stall on the output register.
// Reset (i_rst_n low, synchronous): circular mode, size min(64, STORE_DEPTH), pointers and bank
// lengths zero, no open block; byte store contents undefined, no clearing pass.
module multi_mode_block_byte_buffer_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [15:0]                 i_s_tdata,  // block_length[6:0], write_byte[14:7], first_of_block[15]
    input  logic                        i_s_tuser,  // func
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,  // read_byte[7:0], ok[8], zero[15:9]
    output logic                        o_m_tuser,  // kind
    output logic                        o_m_tlast,  // last
    // register writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [mmbb_pkg::CFG_W-1:0]  i_cfg_data
);
    import mmbb_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic              cfg_we;
    logic [BYTE_W-1:0] out_byte;
    logic              out_ok;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // controller
    mmbb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_m_tready(i_m_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // datapath
    mmbb_dp #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_func     (i_s_tuser),
        .i_len      (i_s_tdata[6:0]),
        .i_wbyte    (i_s_tdata[14:7]),
        .i_first    (i_s_tdata[15]),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_m_tvalid),
        .o_out_kind (o_m_tuser),
        .o_out_byte (out_byte),
        .o_out_ok   (out_ok),
        .o_out_last (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, out_ok, out_byte};

    // a result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load_status || cmd.out_load_data) |-> (!o_m_tvalid || i_m_tready))
        else $error("output register overwritten while stalled");

    // one beat at a time: no new beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while previous beat in flight");

    // a status result always closes its item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_STATUS)) |-> o_m_tlast)
        else $error("status result without last");
endmodule
